FILE: design/kfd_pkg.sv
// Shared constants and types for the H.264 keyframe detector.
// No dependencies; compiled first.
`timescale 1ns / 1ps
`default_nettype none

package kfd_pkg;

  localparam int LengthBitsDefault = 32;
  localparam int AccumBits = 32;
  localparam int PrefixBytes = 4;

  localparam logic [7:0] NalTypeMask = 8'h1F;
  localparam logic [7:0] NalTypeIdr = 8'h05;
  localparam logic [23:0] StartCode = 24'h000001;
  localparam logic [23:0] RecentReset = 24'hFFFFFF;

  typedef struct packed {
    logic is_keyframe;
    logic length_prefixed;
  } kfd_result_t;

endpackage

`default_nettype wire

FILE: design/kfd_if.sv
// Valid/ready channel interfaces: packet bytes in, per-packet results out.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface kfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface kfd_result_if;
  logic valid;
  logic ready;
  logic is_keyframe;
  logic length_prefixed;

  modport source (output valid, output is_keyframe, output length_prefixed, input ready);
  modport sink (input valid, input is_keyframe, input length_prefixed, output ready);
endinterface

`default_nettype wire

FILE: design/kfd_parser.sv
// Per-packet parse state: format detection, Annex B and AVCC header search.
// Depends on kfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kfd_parser
  import kfd_pkg::*;
#(
  parameter int LENGTH_BITS = LengthBitsDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        beat,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,
  output logic             res_valid,
  output kfd_result_t      res
);

  logic [2:0]             byte_position, byte_position_next;
  logic [23:0]            recent_bytes, recent_bytes_next;
  logic                   annexb_mode, annexb_mode_next;
  logic                   idr_found, idr_found_next;
  logic [2:0]             prefix_bytes_read, prefix_bytes_read_next;
  logic [AccumBits-1:0]   nal_length_accum, nal_length_accum_next;
  logic [LENGTH_BITS-1:0] skip_remaining, skip_remaining_next;

  logic                   is_idr;
  logic                   avcc_hit;
  logic [LENGTH_BITS-1:0] nal_len;

  assign is_idr = (data_byte & NalTypeMask) == NalTypeIdr;
  assign nal_len = ((nal_length_accum >> LENGTH_BITS) != '0)
                   ? '1 : nal_length_accum[LENGTH_BITS-1:0];

  always_comb begin
    annexb_mode_next = annexb_mode;
    if (byte_position == 3'd2 && recent_bytes[15:0] == 16'h0000 && data_byte == 8'h01) begin
      annexb_mode_next = 1'b1;
    end
    if (byte_position == 3'd3 && recent_bytes == 24'h000000 && data_byte == 8'h01) begin
      annexb_mode_next = 1'b1;
    end

    avcc_hit = 1'b0;
    skip_remaining_next = skip_remaining;
    prefix_bytes_read_next = prefix_bytes_read;
    nal_length_accum_next = nal_length_accum;
    if (skip_remaining != '0) begin
      skip_remaining_next = skip_remaining - 1'b1;
    end else if (prefix_bytes_read == 3'(PrefixBytes)) begin
      avcc_hit = is_idr;
      if (nal_len != '0) begin
        skip_remaining_next = nal_len - 1'b1;
        prefix_bytes_read_next = '0;
        nal_length_accum_next = '0;
      end else begin
        // zero length: this byte opens the next length field
        prefix_bytes_read_next = 3'd1;
        nal_length_accum_next = AccumBits'(data_byte);
      end
    end else begin
      prefix_bytes_read_next = prefix_bytes_read + 3'd1;
      nal_length_accum_next = {nal_length_accum[AccumBits-9:0], data_byte};
    end

    idr_found_next = idr_found
                   | (annexb_mode && recent_bytes == StartCode && is_idr)
                   | (!annexb_mode_next && avcc_hit);

    recent_bytes_next = {recent_bytes[15:0], data_byte};
    byte_position_next = (byte_position < 3'(PrefixBytes)) ? byte_position + 3'd1
                                                            : byte_position;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      recent_bytes <= RecentReset;
      annexb_mode <= 1'b0;
      idr_found <= 1'b0;
      prefix_bytes_read <= '0;
      nal_length_accum <= '0;
      skip_remaining <= '0;
    end else if (beat) begin
      if (last_byte) begin
        byte_position <= '0;
        recent_bytes <= RecentReset;
        annexb_mode <= 1'b0;
        idr_found <= 1'b0;
        prefix_bytes_read <= '0;
        nal_length_accum <= '0;
        skip_remaining <= '0;
      end else begin
        byte_position <= byte_position_next;
        recent_bytes <= recent_bytes_next;
        annexb_mode <= annexb_mode_next;
        idr_found <= idr_found_next;
        prefix_bytes_read <= prefix_bytes_read_next;
        nal_length_accum <= nal_length_accum_next;
        skip_remaining <= skip_remaining_next;
      end
    end
  end

  assign res_valid = beat && last_byte;
  assign res.is_keyframe = idr_found_next;
  assign res.length_prefixed = !annexb_mode_next;

endmodule

`default_nettype wire

FILE: design/kfd_out_reg.sv
// Result register: holds one per-packet result until the receiver takes it.
// Depends on kfd_pkg and kfd_result_if.
`timescale 1ns / 1ps
`default_nettype none

module kfd_out_reg
  import kfd_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         load,
  input  wire kfd_result_t  res,
  output logic              can_load,
  kfd_result_if.source      result
);

  logic        full;
  kfd_result_t held;

  assign can_load = !full || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (load) begin
      full <= 1'b1;
    end else if (result.ready) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

  assign result.valid = full;
  assign result.is_keyframe = held.is_keyframe;
  assign result.length_prefixed = held.length_prefixed;

endmodule

`default_nettype wire

FILE: design/h264_keyframe_detector.sv
// H.264 keyframe detector top level: byte-stream parser and result register.
// Depends on kfd_pkg, kfd_if, kfd_parser and kfd_out_reg.
//
// Usage:
//   pkt carries one packet byte per beat, last_byte set on the final byte.
//   result carries one beat per packet: is_keyframe is set if any NAL
//   header of type 5 was seen, length_prefixed is set for AVCC framing and
//   clear for Annex B (start code 00 00 01 or 00 00 00 01 at the head).
//   Throughput is one byte per cycle while pkt.ready is high; every byte
//   is parsed in the cycle it is accepted. The result appears on result
//   in the cycle after the last byte is accepted. Packets of fewer than
//   four bytes never report a keyframe.
//   While a result waits for the receiver, bytes of the next packet keep
//   flowing; only the last byte of the following packet is held off, by
//   pkt.ready going low, until the waiting result is taken.
//   Reset clears the parse state and drops any waiting result.
`timescale 1ns / 1ps
`default_nettype none

module h264_keyframe_detector
  import kfd_pkg::*;
#(
  parameter int LENGTH_BITS = LengthBitsDefault
) (
  input  wire logic    clk,
  input  wire logic    rst,
  kfd_byte_if.sink     pkt,
  kfd_result_if.source result
);

  logic        can_load;
  logic        beat;
  logic        res_valid;
  kfd_result_t res;

  assign pkt.ready = can_load || !pkt.last_byte;
  assign beat = pkt.valid && pkt.ready;

  kfd_parser #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .beat      (beat),
    .data_byte (pkt.data_byte),
    .last_byte (pkt.last_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  kfd_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .load     (res_valid),
    .res      (res),
    .can_load (can_load),
    .result   (result)
  );

endmodule

`default_nettype wire
